/* rtl/btk_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// btk_pkg: shared types and constants of the bounded top-k score list
// Entry record, command and register codes, cell control bundle.
// ----------------------------------------------------------------------------
package btk_pkg;

   localparam int MAX_ENTRIES_DEF = 64;

   localparam int SCORE_W = 16;
   localparam int CLASS_W = 7;
   localparam int COORD_W = 16;
   localparam int CFG_W   = 7;
   localparam int RANK_W  = 6;
   localparam int COUNT_W = 7;
   localparam int CMD_W   = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_READ   = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAPACITY   = 1'b0,
      CSR_KEEP_LIMIT = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [SCORE_W-1:0] quality;
      logic [CLASS_W-1:0] class_index;
      logic [COORD_W-1:0] left_x;
      logic [COORD_W-1:0] top_y;
      logic [COORD_W-1:0] right_x;
      logic [COORD_W-1:0] bottom_y;
   } entry_type;

   // broadcast to every cell each cycle
   typedef struct packed {
      logic insert;   // place candidate, shift lower entries down
      logic rotate;   // move kept entries up by one, head wraps to tail
   } cell_ctl_type;

endpackage : btk_pkg
`default_nettype wire

/* rtl/btk_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// btk_cell: one slot of the sorted list
// Holds one entry; compares against the broadcast candidate and takes data
// from its upper or lower neighbor on insert or read-out rotation.
// ----------------------------------------------------------------------------
module btk_cell #(
   parameter int IDX_W = 6,
   parameter int IDX   = 0
) (
   input  wire logic                 clock,
   input  wire btk_pkg::cell_ctl_type ctl,
   input  wire logic [IDX_W-1:0]     slot_idx,
   input  wire logic [IDX_W-1:0]     last_idx,
   input  wire btk_pkg::entry_type   cand,
   input  wire btk_pkg::entry_type   left_entry,
   input  wire logic                 left_lt,
   input  wire btk_pkg::entry_type   right_entry,
   input  wire btk_pkg::entry_type   head_entry,
   output      btk_pkg::entry_type   entry,
   output      logic                 lt,
   output      logic                 last_hit
);
   import btk_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

   entry_type entry_ff;
   entry_type entry_in;
   logic      act;
   logic      below;

   assign act      = (MY_IDX <= slot_idx);
   assign below    = (entry_ff.score < cand.score);
   assign lt       = act & ((MY_IDX == slot_idx) | below);
   assign last_hit = (MY_IDX == last_idx) & below;
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert && act) begin
         if (left_lt) begin
            entry_in = left_entry;
         end else if (lt) begin
            entry_in = cand;
         end
      end
      if (ctl.rotate) begin
         if (MY_IDX == last_idx) begin
            entry_in = head_entry;
         end else if (MY_IDX < last_idx) begin
            entry_in = right_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule : btk_cell
`default_nettype wire

/* rtl/bounded_top_k_score_list_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_top_k_score_list_unit: top-k detection list, descending score
// Insertion-sorted chain of cells with clear, insert and read-out commands.
// ----------------------------------------------------------------------------
// Clear and insert: a transaction can be taken every cycle while req_stall is low.
// Read: the accepted request enters ST_READ, which loads the first result into the
//   output register, then one per cycle while rsp_stall is low; a run is kept_count
//   results (one for an empty list) and req_stall stays high until the last is loaded.
// Reset clears the kept count and sets capacity and keep_limit to 64;
//   entry registers are not reset.
module bounded_top_k_score_list_unit #(
   parameter int MAX_ENTRIES = btk_pkg::MAX_ENTRIES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // configuration
   input  wire logic                          csr_write_enable,
   input  wire logic [btk_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [btk_pkg::CFG_W-1:0]     csr_data,
   // request channel
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [btk_pkg::CMD_W-1:0]     req_command,
   input  wire logic [btk_pkg::SCORE_W-1:0]   req_score,
   input  wire logic [btk_pkg::SCORE_W-1:0]   req_quality,
   input  wire logic [btk_pkg::CLASS_W-1:0]   req_class_index,
   input  wire logic [btk_pkg::COORD_W-1:0]   req_left_x,
   input  wire logic [btk_pkg::COORD_W-1:0]   req_top_y,
   input  wire logic [btk_pkg::COORD_W-1:0]   req_right_x,
   input  wire logic [btk_pkg::COORD_W-1:0]   req_bottom_y,
   // response channel
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic                          rsp_entry_valid,
   output      logic [btk_pkg::RANK_W-1:0]    rsp_rank,
   output      logic [btk_pkg::SCORE_W-1:0]   rsp_out_score,
   output      logic [btk_pkg::SCORE_W-1:0]   rsp_out_quality,
   output      logic [btk_pkg::CLASS_W-1:0]   rsp_out_class,
   output      logic [btk_pkg::COORD_W-1:0]   rsp_out_left_x,
   output      logic [btk_pkg::COORD_W-1:0]   rsp_out_top_y,
   output      logic [btk_pkg::COORD_W-1:0]   rsp_out_right_x,
   output      logic [btk_pkg::COORD_W-1:0]   rsp_out_bottom_y,
   output      logic [btk_pkg::COUNT_W-1:0]   rsp_entry_count,
   output      logic                          rsp_last_item
);
   import btk_pkg::*;

   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int BW = (CW > CFG_W) ? CW : CFG_W;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

   // ---------------------------------------------------------------- config
   logic [CFG_W-1:0] capacity_ff, capacity_in;
   logic [CFG_W-1:0] keep_limit_ff, keep_limit_in;

   always_comb begin
      capacity_in   = capacity_ff;
      keep_limit_in = keep_limit_ff;
      if (csr_write_enable) begin
         case (csr_idx_type'(csr_index))
            CSR_CAPACITY:   capacity_in   = csr_data;
            CSR_KEEP_LIMIT: keep_limit_in = csr_data;
            default: ;
         endcase
      end
   end

   // Effective bound: min(capacity, keep_limit, MAX_ENTRIES)
   logic [CFG_W-1:0] cfg_min;
   logic [BW-1:0]    bound;
   assign cfg_min = (capacity_ff < keep_limit_ff) ? capacity_ff : keep_limit_ff;
   assign bound   = (BW'(cfg_min) < BW'(MAX_ENTRIES)) ? BW'(cfg_min) : BW'(MAX_ENTRIES);

   // ---------------------------------------------------------------- control
   state_type      state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [IW-1:0]  rd_idx_ff, rd_idx_in;
   logic [CW-1:0]  count_m1;
   logic [IW-1:0]  last_idx;
   logic [IW-1:0]  slot_idx;
   logic           req_accept;
   logic           grow;
   logic           last_lt;
   logic           ins_ok;
   logic           out_free;
   logic           rd_load;
   logic           rd_done;
   cell_ctl_type   ctl;
   entry_type      cand;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid & ~req_stall;

   assign count_m1 = count_ff - CW'(1);
   assign last_idx = count_m1[IW-1:0];
   assign grow     = (BW'(count_ff) < bound);
   assign slot_idx = grow ? count_ff[IW-1:0] : last_idx;

   // Full list: the candidate must strictly beat the tail entry.
   assign ins_ok = req_accept && (cmd_type'(req_command) == CMD_INSERT)
                   && (req_score != '0) && (capacity_ff != '0) && (keep_limit_ff != '0)
                   && (grow || ((count_ff != '0) && last_lt));

   assign cand.score       = req_score;
   assign cand.quality     = req_quality;
   assign cand.class_index = req_class_index;
   assign cand.left_x      = req_left_x;
   assign cand.top_y       = req_top_y;
   assign cand.right_x     = req_right_x;
   assign cand.bottom_y    = req_bottom_y;

   // Output register free when empty or drained this cycle.
   logic rsp_valid_ff, rsp_valid_in;
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign rd_load  = (state_ff == ST_READ) && out_free;
   assign rd_done  = (count_ff == '0) || (rd_idx_ff == last_idx);

   assign ctl.insert = ins_ok;
   assign ctl.rotate = rd_load && (count_ff != '0);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      rd_idx_in = rd_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (cmd_type'(req_command))
                  CMD_CLEAR:  count_in = '0;
                  CMD_INSERT: begin
                     if (ins_ok && grow) begin
                        count_in = count_ff + CW'(1);
                     end
                  end
                  CMD_READ: begin
                     state_in  = ST_READ;
                     rd_idx_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            if (rd_load) begin
               rd_idx_in = rd_idx_ff + IW'(1);
               if (rd_done) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- cells
   entry_type             cell_entry [MAX_ENTRIES];
   entry_type             left_ent   [MAX_ENTRIES];
   entry_type             right_ent  [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] cell_lt;
   logic [MAX_ENTRIES-1:0] left_lt;
   logic [MAX_ENTRIES-1:0] cell_hit;

   assign last_lt = |cell_hit;

   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      if (g == 0) begin : g_first
         assign left_lt[g]  = 1'b0;
         assign left_ent[g] = cand;
      end else begin : g_mid
         assign left_lt[g]  = cell_lt[g-1];
         assign left_ent[g] = cell_entry[g-1];
      end
      if (g == MAX_ENTRIES - 1) begin : g_tail
         assign right_ent[g] = cell_entry[g];
      end else begin : g_body
         assign right_ent[g] = cell_entry[g+1];
      end

      btk_cell #(
         .IDX_W (IW),
         .IDX   (g)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .slot_idx    (slot_idx),
         .last_idx    (last_idx),
         .cand        (cand),
         .left_entry  (left_ent[g]),
         .left_lt     (left_lt[g]),
         .right_entry (right_ent[g]),
         .head_entry  (cell_entry[0]),
         .entry       (cell_entry[g]),
         .lt          (cell_lt[g]),
         .last_hit    (cell_hit[g])
      );
   end

   // ---------------------------------------------------------------- output
   // Head cell is read each step; rotation brings the next rank to the head
   // and after kept_count steps the list is back in its original order.
   entry_type          out_entry_ff, out_entry_in;
   logic               out_evalid_ff, out_evalid_in;
   logic [RANK_W-1:0]  out_rank_ff, out_rank_in;
   logic [COUNT_W-1:0] out_count_ff, out_count_in;
   logic               out_last_ff, out_last_in;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      out_entry_in  = out_entry_ff;
      out_evalid_in = out_evalid_ff;
      out_rank_in   = out_rank_ff;
      out_count_in  = out_count_ff;
      out_last_in   = out_last_ff;
      if (rd_load) begin
         rsp_valid_in = 1'b1;
         out_count_in = COUNT_W'(count_ff);
         out_last_in  = rd_done;
         if (count_ff == '0) begin
            out_entry_in  = '0;
            out_evalid_in = 1'b0;
            out_rank_in   = '0;
         end else begin
            out_entry_in  = cell_entry[0];
            out_evalid_in = 1'b1;
            out_rank_in   = RANK_W'(rd_idx_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rd_idx_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         capacity_ff   <= CFG_RESET;
         keep_limit_ff <= CFG_RESET;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rd_idx_ff     <= rd_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
         capacity_ff   <= capacity_in;
         keep_limit_ff <= keep_limit_in;
      end
   end

   always_ff @(posedge clock) begin
      out_entry_ff  <= out_entry_in;
      out_evalid_ff <= out_evalid_in;
      out_rank_ff   <= out_rank_in;
      out_count_ff  <= out_count_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_entry_valid  = out_evalid_ff;
   assign rsp_rank         = out_rank_ff;
   assign rsp_out_score    = out_entry_ff.score;
   assign rsp_out_quality  = out_entry_ff.quality;
   assign rsp_out_class    = out_entry_ff.class_index;
   assign rsp_out_left_x   = out_entry_ff.left_x;
   assign rsp_out_top_y    = out_entry_ff.top_y;
   assign rsp_out_right_x  = out_entry_ff.right_x;
   assign rsp_out_bottom_y = out_entry_ff.bottom_y;
   assign rsp_entry_count  = out_count_ff;
   assign rsp_last_item    = out_last_ff;

endmodule : bounded_top_k_score_list_unit
`default_nettype wire

/* rtl/btk_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// btk_checker: port-level checks for the top-k list unit
// Read-out run framing and response channel hold rules.
// ----------------------------------------------------------------------------
module btk_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic [btk_pkg::CMD_W-1:0]     req_command,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic                          rsp_entry_valid,
   input wire logic [btk_pkg::RANK_W-1:0]    rsp_rank,
   input wire logic [btk_pkg::SCORE_W-1:0]   rsp_out_score,
   input wire logic [btk_pkg::COUNT_W-1:0]   rsp_entry_count,
   input wire logic                          rsp_last_item
);
   import btk_pkg::*;

   // empty-list transaction is a single, zeroed item
   a_empty_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_entry_valid) |->
         (rsp_last_item && rsp_entry_count == '0 && rsp_rank == '0))
      else $error("empty-list item malformed");

   // last entry of a run carries rank count-1
   a_last_rank: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_entry_valid && rsp_last_item) |->
         (COUNT_W'(rsp_rank) + COUNT_W'(1) == rsp_entry_count))
      else $error("last item rank does not match entry count");

   // a read request blocks the request channel next cycle
   a_read_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_command == CMD_READ) |=> req_stall)
      else $error("request accepted during read-out");

   // mid-run result implies request channel is blocked
   a_run_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_item) |-> req_stall)
      else $error("request channel open during unfinished read-out");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_score)
         && $stable(rsp_rank) && $stable(rsp_last_item)))
      else $error("stalled response changed");

endmodule : btk_checker

bind bounded_top_k_score_list_unit btk_checker u_btk_checker (.*);
`default_nettype wire
